@@ rtl/wss_pkg.sv @@
// Shared constants, register codes and types of the wildcard signature search unit.
package wss_pkg;

    localparam int MAX_PATTERN_DEF   = 32;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int PATTERN_BYTES     = 32;
    localparam int PATTERN_IDX_BITS  = 5;
    localparam int PATTERN_WORD_BITS = 64;
    localparam int LENGTH_BITS       = 6;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int MATCH_OFFSET_BITS = 32;

    localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_WORD_0 = 3'd0,
        CFG_PATTERN_WORD_1 = 3'd1,
        CFG_PATTERN_WORD_2 = 3'd2,
        CFG_PATTERN_WORD_3 = 3'd3,
        CFG_PATTERN_LENGTH = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic                         found;
        logic [MATCH_OFFSET_BITS-1:0] match_offset;
    } t_result;

endpackage

@@ rtl/wss_if.sv @@
// Handshake interfaces for the data, result and configuration channels.
interface wss_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, data_byte, last, input ready);
    modport sink   (input valid, data_byte, last, output ready);
endinterface

interface wss_out_if import wss_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [MATCH_OFFSET_BITS-1:0] match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

interface wss_cfg_if import wss_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [CFG_INDEX_BITS-1:0]    index;
    logic [PATTERN_WORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/wss_cell.sv @@
// One window cell: holds one data byte, passes it on and compares its incoming byte.
module wss_cell import wss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic       i_care,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_en) begin
            r_byte <= i_clear ? 8'h00 : i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_care || (i_pat == WILDCARD_BYTE) || (i_pat == i_byte);

endmodule

@@ rtl/wss_obuf.sv @@
// Result output register with a one-entry skid stage.
module wss_obuf import wss_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_result,
    output logic          o_space,
    wss_out_if.source     o_out
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= i_push;
                r_skid       <= i_result;
            end else begin
                r_out_valid <= i_push;
                r_out       <= i_result;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_result;
        end
    end

    assign o_space            = !r_skid_valid;
    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out.found;
    assign o_out.match_offset = r_out.match_offset;

endmodule

@@ rtl/wildcard_signature_search_unit.sv @@
// Top level of the wildcard signature search unit: a row of window cells and a result buffer.
//
// Data bytes arrive on i_data, one per transfer, with last marking the final byte of a block.
// Each block yields exactly one result on o_result: found set with the start offset of the
// first match, or found clear with offset 0 when the block ends without a match.
// The pattern (up to 32 bytes, 0x3F matching any byte) and its length are written on i_cfg
// while no block is in progress; the configuration channel is always ready.
// A byte is taken every cycle while i_data.ready is high. The window shifts one cell per
// transfer and all cells compare in the same cycle, so a result is registered in the cycle
// after the transfer of the byte that decides it, in the output register or the skid stage.
// The output register and a one-entry skid stage hold results while the receiver stalls;
// i_data.ready drops only when both are full.
// Reset clears the pattern to zeros, sets the length to one and clears the block state.
module wildcard_signature_search_unit import wss_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wss_cfg_if.sink    i_cfg,
    wss_in_if.sink     i_data,
    wss_out_if.source  o_result
);

    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int LCW = (LW > LENGTH_BITS) ? LW : LENGTH_BITS;
    localparam int IW  = (LW > PATTERN_IDX_BITS) ? LW : PATTERN_IDX_BITS;
    localparam int WB  = (OFFSET_BITS > MATCH_OFFSET_BITS) ? OFFSET_BITS : MATCH_OFFSET_BITS;

    logic [PATTERN_BYTES*8-1:0] r_pattern;
    logic [LENGTH_BITS-1:0]     r_length;
    logic [OFFSET_BITS-1:0]     r_bytes_seen;
    logic                       r_match_reported;

    logic [LCW-1:0]         w_len_ext;
    logic [LW-1:0]          w_len;
    logic [OFFSET_BITS-1:0] w_start_gap;
    logic [OFFSET_BITS-1:0] w_diff;
    logic [WB-1:0]          w_diff_w;
    logic [7:0]             w_pat  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_care;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [7:0]             w_win  [MAX_PATTERN-1];
    logic                   w_acc;
    logic                   w_pos_ok;
    logic                   w_found;
    logic                   w_push;
    logic                   w_space;
    t_result                w_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LENGTH_BITS'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_PATTERN_WORD_0: r_pattern[0*PATTERN_WORD_BITS +: PATTERN_WORD_BITS] <= i_cfg.data;
                CFG_PATTERN_WORD_1: r_pattern[1*PATTERN_WORD_BITS +: PATTERN_WORD_BITS] <= i_cfg.data;
                CFG_PATTERN_WORD_2: r_pattern[2*PATTERN_WORD_BITS +: PATTERN_WORD_BITS] <= i_cfg.data;
                CFG_PATTERN_WORD_3: r_pattern[3*PATTERN_WORD_BITS +: PATTERN_WORD_BITS] <= i_cfg.data;
                CFG_PATTERN_LENGTH: r_length <= i_cfg.data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_len_ext = LCW'(r_length);
        if (w_len_ext == '0) begin
            w_len_ext = LCW'(1);
        end else if (w_len_ext > LCW'(MAX_PATTERN)) begin
            w_len_ext = LCW'(MAX_PATTERN);
        end
        w_len = w_len_ext[LW-1:0];
    end

    // Cell j takes in the byte j places back from the newest one and is matched
    // against pattern byte length-1-j; pattern bytes without a register are wildcards.
    always_comb begin
        logic [IW-1:0] v_idx;
        v_idx = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_care[j] = LW'(j) < w_len;
            v_idx     = IW'(w_len) - IW'(1) - IW'(j);
            if (w_care[j] && (int'(v_idx) < PATTERN_BYTES)) begin
                w_pat[j] = r_pattern[{v_idx[PATTERN_IDX_BITS-1:0], 3'b000} +: 8];
            end else begin
                w_pat[j] = WILDCARD_BYTE;
            end
        end
    end

    assign w_acc = i_data.valid && i_data.ready;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            logic [7:0] w_in;
            if (g == 0) begin : g_head
                assign w_in = i_data.data_byte;
            end else begin : g_link
                assign w_in = w_win[g-1];
            end
            if (g == MAX_PATTERN - 1) begin : g_tail
                wss_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_acc),
                    .i_clear (i_data.last),
                    .i_byte  (w_in),
                    .i_pat   (w_pat[g]),
                    .i_care  (w_care[g]),
                    .o_byte  (),
                    .o_hit   (w_hit[g])
                );
            end else begin : g_body
                wss_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_acc),
                    .i_clear (i_data.last),
                    .i_byte  (w_in),
                    .i_pat   (w_pat[g]),
                    .i_care  (w_care[g]),
                    .o_byte  (w_win[g]),
                    .o_hit   (w_hit[g])
                );
            end
        end
    endgenerate

    assign w_start_gap = OFFSET_BITS'(w_len - LW'(1));
    assign w_pos_ok    = r_bytes_seen >= w_start_gap;
    assign w_diff      = r_bytes_seen - w_start_gap;
    assign w_diff_w    = WB'(w_diff);
    assign w_found     = w_acc && !r_match_reported && w_pos_ok && (&w_hit);
    assign w_push      = w_found || (w_acc && i_data.last && !r_match_reported);

    assign w_result.found        = w_found;
    assign w_result.match_offset = w_found ? w_diff_w[MATCH_OFFSET_BITS-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen     <= '0;
            r_match_reported <= 1'b0;
        end else if (w_acc) begin
            if (i_data.last) begin
                r_bytes_seen     <= '0;
                r_match_reported <= 1'b0;
            end else begin
                if (r_bytes_seen != '1) begin
                    r_bytes_seen <= r_bytes_seen + OFFSET_BITS'(1);
                end
                if (w_found) begin
                    r_match_reported <= 1'b1;
                end
            end
        end
    end

    wss_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_result)
    );

    assign i_data.ready = w_space;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_data.ready |-> o_result.valid)
        else $error("Input stalled while no result is waiting.");

    a_block_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_data.last |=> (r_bytes_seen == '0) && !r_match_reported)
        else $error("Block state not cleared after the last byte.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_reported && w_acc |-> !w_push)
        else $error("Second result produced within one block.");

    a_miss_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.found |-> o_result.match_offset == '0)
        else $error("Result without a match carries a nonzero offset.");

endmodule
